@@ design/tsrr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_pkg: shared types, constants and helpers
// Codes, reset values, divider handshake types and packet byte helpers used
// across the smoothed rpm tachometer.
// ----------------------------------------------------------------------------
package tsrr_pkg;

	localparam int DEFAULT_TIME_BITS = 32;
	localparam int IN_TIME_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int FIFO_DEPTH = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REACTION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

	localparam logic [7:0]  DEBOUNCE_RST = 8'd6;
	localparam logic [9:0]  REACTION_RST = 10'd200;
	localparam logic [15:0] INTERVAL_RST = 16'd100;

	// divider shape: 24-bit numerator, 16-bit saturated denominator
	localparam int DIV_NUM_W = 24;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_STEPS = DIV_NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam int RPM_W  = 14;
	localparam int RPTR_W = 15;
	localparam logic [RPM_W-1:0]     RPM_MAX    = 14'd16383;
	localparam logic [DIV_NUM_W-1:0] SPARK_NUM  = 24'd60000;
	localparam logic [DIV_NUM_W-1:0] STALL_NUM  = 24'd30000;
	localparam logic [RPTR_W-1:0]    HEX_CLAMP  = 15'd8191;

	localparam int PKT_LEN = 6;
	localparam int PKT_IDX_W = 3;
	localparam logic [7:0] CH_R  = 8'h52;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_F  = 8'h46;

	typedef enum logic {
		OP_SPARK = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EVAL,
		B_DIV_A,
		B_MUL,
		B_DIV_B,
		B_DIV_R,
		B_EMIT
	} back_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic [7:0]  debounce;
		logic [9:0]  reaction;
		logic [15:0] interval;
	} cfg_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'd0, nib};
		end else begin
			c = 8'h37 + {4'd0, nib};
		end
		return c;
	endfunction

	function automatic logic [7:0] pkt_byte(input logic [PKT_IDX_W-1:0] idx,
	                                        input logic [RPTR_W-1:0] rpm);
		logic       clamp;
		logic [7:0] b;
		clamp = rpm > HEX_CLAMP;
		case (idx)
			3'd0: b = CH_R;
			3'd1: b = clamp ? CH_F : hex_char(rpm[11:8]);
			3'd2: b = clamp ? CH_F : hex_char(rpm[7:4]);
			3'd3: b = clamp ? CH_F : hex_char(rpm[3:0]);
			3'd4: b = CH_CR;
			3'd5: b = CH_LF;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [RPM_W-1:0] sat_rpm(input logic [DIV_NUM_W:0] v);
		logic [RPM_W-1:0] r;
		if (v > {{(DIV_NUM_W+1-RPM_W){1'b0}}, RPM_MAX}) begin
			r = RPM_MAX;
		end else begin
			r = v[RPM_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ design/tachometer_smoothed_rpm_report_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tachometer_smoothed_rpm_report_top: smoothed tachometer with ASCII reports
// Measures spark periods, keeps an exponentially smoothed rpm, and on due
// report ticks sends "R" + three hex digits + CR LF.
// ----------------------------------------------------------------------------
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+----------------------------------------
// s_*     | in  | s_tvalid/s_tready  | tdata = time_ms, tuser = opcode
// m_*     | out | m_tvalid/m_tready  | tdata = packet_byte, reported_rpm; tlast
// cfg_*   | in  | cfg_we             | cfg_index selects register, cfg_data
//
// Flow: the front takes a word whenever the two-entry queue has room.
// The back pops one command at a time; a spark within the debounce time is
// dropped, else it runs one division (period at or above the window) or two
// divisions with a multiply step between; a due report runs one division
// when stalled, then sends one byte per cycle while the output is free.
// Both share the 24-step restoring divider.
// Reset clears the schedule, the spark state and all handshake flags.
// A stalled output holds its byte; the back waits, the queue fills, then
// s_tready drops.
module tachometer_smoothed_rpm_report_top #(
	parameter int TIME_BITS = tsrr_pkg::DEFAULT_TIME_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input words
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [tsrr_pkg::IN_TIME_W-1:0]     s_tdata,  // [31:0] time_ms
	input  logic                               s_tuser,  // [0] opcode
	// report bytes
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,  // [7:0] packet_byte,
	                                                     // [22:8] reported_rpm, [23] 0
	output logic                               m_tlast,  // last_byte
	// configuration writes
	input  logic                               cfg_we,
	input  logic [tsrr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsrr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	tsrr_pkg::cfg_t cfg_q;

	logic                           push;
	logic [TIME_BITS:0]             push_data;
	logic                           full;
	logic                           pop;
	logic [TIME_BITS:0]             head;
	logic                           empty;
	tsrr_pkg::div_req_t             div_req;
	tsrr_pkg::div_rsp_t             div_rsp;
	logic [7:0]                     out_byte;
	logic [tsrr_pkg::RPTR_W-1:0]    out_rpm;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce <= tsrr_pkg::DEBOUNCE_RST;
			cfg_q.reaction <= tsrr_pkg::REACTION_RST;
			cfg_q.interval <= tsrr_pkg::INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tsrr_pkg::CFG_DEBOUNCE: cfg_q.debounce <= cfg_data[7:0];
				tsrr_pkg::CFG_REACTION: cfg_q.reaction <= cfg_data[9:0];
				tsrr_pkg::CFG_INTERVAL: cfg_q.interval <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: classify words, drop report ticks that are not yet due
	tsrr_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.interval  (cfg_q.interval),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// command queue: {opcode, time}
	tsrr_fifo #(
		.W (TIME_BITS + 1)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	tsrr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// back: spark math, stall estimate and packet serializer
	tsrr_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_byte   (out_byte),
		.m_last   (m_tlast),
		.m_rpm    (out_rpm)
	);

	assign m_tdata = {1'b0, out_rpm, out_byte};

endmodule

@@ design/tsrr_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_fifo: command queue
// Two-entry queue between the classifier and the execution engine.
// ----------------------------------------------------------------------------
module tsrr_fifo #(
	parameter int W = tsrr_pkg::DEFAULT_TIME_BITS + 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	localparam int PTR_W = $clog2(tsrr_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(tsrr_pkg::FIFO_DEPTH + 1);

	logic [W-1:0]     mem_q [tsrr_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = cnt_q == CNT_W'(tsrr_pkg::FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(tsrr_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(tsrr_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/tsrr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_front: input classifier
// Takes input words, forwards sparks, and keeps the report schedule so that
// only due report ticks reach the queue.
// ----------------------------------------------------------------------------
module tsrr_front #(
	parameter int TIME_BITS = tsrr_pkg::DEFAULT_TIME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tsrr_pkg::IN_TIME_W-1:0]   s_tdata,
	input  logic                             s_tuser,
	input  logic [15:0]                      interval,
	output logic                             push,
	output logic [TIME_BITS:0]               push_data,
	input  logic                             full
);

	logic [TIME_BITS-1:0] next_report_q;
	logic [TIME_BITS-1:0] now;
	logic                 take;
	logic                 due;

	assign s_tready  = !full;
	assign take      = s_tvalid && s_tready;
	assign now       = TIME_BITS'(s_tdata);
	assign due       = now >= next_report_q;
	assign push      = take && (tsrr_pkg::op_t'(s_tuser) == tsrr_pkg::OP_SPARK || due);
	assign push_data = {s_tuser, now};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_report_q <= '0;
		end else if (take && tsrr_pkg::op_t'(s_tuser) == tsrr_pkg::OP_TICK && due) begin
			next_report_q <= now + TIME_BITS'(interval);
		end
	end

endmodule

@@ design/tsrr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_div: restoring divider
// One quotient bit per cycle; done pulses with the quotient after the last.
// ----------------------------------------------------------------------------
module tsrr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tsrr_pkg::div_req_t req,
	output tsrr_pkg::div_rsp_t rsp
);

	logic [tsrr_pkg::DIV_NUM_W-1:0] num_q;
	logic [tsrr_pkg::DIV_DEN_W-1:0] den_q;
	logic [tsrr_pkg::DIV_DEN_W-1:0] rem_q;
	logic [tsrr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [tsrr_pkg::DIV_DEN_W:0]   trial;
	logic                           fits;

	assign trial    = {rem_q, num_q[tsrr_pkg::DIV_NUM_W-1]};
	assign fits     = trial >= {1'b0, den_q};
	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[tsrr_pkg::DIV_NUM_W-2:0], fits};
			rem_q <= fits ? tsrr_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
			              : trial[tsrr_pkg::DIV_DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= tsrr_pkg::DIV_CNT_W'(tsrr_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tsrr_pkg::DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ design/tsrr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsrr_back: execution engine
// Runs spark updates and reports from the queue on the shared divider and
// serializes report packets into the output register.
// ----------------------------------------------------------------------------
module tsrr_back #(
	parameter int TIME_BITS = tsrr_pkg::DEFAULT_TIME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tsrr_pkg::cfg_t                   cfg,
	input  logic                             empty,
	input  logic [TIME_BITS:0]               head,
	output logic                             pop,
	output tsrr_pkg::div_req_t               div_req,
	input  tsrr_pkg::div_rsp_t               div_rsp,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_byte,
	output logic                             m_last,
	output logic [tsrr_pkg::RPTR_W-1:0]      m_rpm
);

	tsrr_pkg::back_state_t state_q, state_d;

	logic [TIME_BITS-1:0]              last_spark_q;
	logic [tsrr_pkg::RPM_W-1:0]        smoothed_q;
	logic [TIME_BITS-1:0]              time_q;
	logic [TIME_BITS-1:0]              diff_q;
	tsrr_pkg::op_t                     kind_q;
	logic                              dir_q;
	logic [15:0]                       q1_q;
	logic [tsrr_pkg::RPTR_W-1:0]       rpm_q;
	logic [tsrr_pkg::PKT_IDX_W-1:0]    idx_q;
	logic                              out_valid_q;
	logic [7:0]                        out_byte_q;
	logic                              out_last_q;
	logic [tsrr_pkg::RPTR_W-1:0]       out_rpm_q;

	logic                              spark_drop;
	logic                              spark_direct;
	logic                              stall;
	logic [tsrr_pkg::DIV_DEN_W-1:0]    den_sat;
	logic [9:0]                        span;
	logic [tsrr_pkg::DIV_NUM_W-1:0]    prod;
	logic                              out_load;
	logic                              idx_end;

	assign spark_drop   = diff_q == '0 || diff_q < TIME_BITS'(cfg.debounce);
	assign spark_direct = diff_q >= TIME_BITS'(cfg.reaction);
	assign stall        = diff_q > TIME_BITS'(cfg.interval);
	// periods past 16 bits give a zero quotient, as does the largest 16-bit one
	assign den_sat      = ((diff_q >> 16) != '0) ? '1 : diff_q[15:0];
	assign span         = cfg.reaction - diff_q[9:0];
	assign prod         = tsrr_pkg::DIV_NUM_W'(span) * tsrr_pkg::DIV_NUM_W'(smoothed_q);
	assign idx_end      = idx_q == tsrr_pkg::PKT_IDX_W'(tsrr_pkg::PKT_LEN - 1);

	assign m_tvalid = out_valid_q;
	assign m_byte   = out_byte_q;
	assign m_last   = out_last_q;
	assign m_rpm    = out_rpm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsrr_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		div_req  = '0;
		case (state_q)
			tsrr_pkg::B_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = tsrr_pkg::B_EVAL;
				end
			end
			tsrr_pkg::B_EVAL: begin
				if (kind_q == tsrr_pkg::OP_SPARK) begin
					if (spark_drop) begin
						state_d = tsrr_pkg::B_IDLE;
					end else begin
						div_req.start = 1'b1;
						div_req.num   = tsrr_pkg::SPARK_NUM;
						div_req.den   = spark_direct ? den_sat
						                             : tsrr_pkg::DIV_DEN_W'(cfg.reaction);
						state_d       = tsrr_pkg::B_DIV_A;
					end
				end else if (stall) begin
					div_req.start = 1'b1;
					div_req.num   = tsrr_pkg::STALL_NUM;
					div_req.den   = den_sat;
					state_d       = tsrr_pkg::B_DIV_R;
				end else begin
					state_d = tsrr_pkg::B_EMIT;
				end
			end
			tsrr_pkg::B_DIV_A: begin
				if (div_rsp.done) begin
					state_d = dir_q ? tsrr_pkg::B_IDLE : tsrr_pkg::B_MUL;
				end
			end
			tsrr_pkg::B_MUL: begin
				div_req.start = 1'b1;
				div_req.num   = prod;
				div_req.den   = tsrr_pkg::DIV_DEN_W'(cfg.reaction);
				state_d       = tsrr_pkg::B_DIV_B;
			end
			tsrr_pkg::B_DIV_B: begin
				if (div_rsp.done) begin
					state_d = tsrr_pkg::B_IDLE;
				end
			end
			tsrr_pkg::B_DIV_R: begin
				if (div_rsp.done) begin
					state_d = tsrr_pkg::B_EMIT;
				end
			end
			tsrr_pkg::B_EMIT: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					if (idx_end) begin
						state_d = tsrr_pkg::B_IDLE;
					end
				end
			end
			default: state_d = tsrr_pkg::B_IDLE;
		endcase
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_spark_q <= '0;
			smoothed_q   <= '0;
			idx_q        <= '0;
		end else begin
			if (state_q == tsrr_pkg::B_DIV_A && div_rsp.done && dir_q) begin
				smoothed_q   <= tsrr_pkg::sat_rpm({1'b0, div_rsp.quo});
				last_spark_q <= time_q;
			end
			if (state_q == tsrr_pkg::B_DIV_B && div_rsp.done) begin
				smoothed_q   <= tsrr_pkg::sat_rpm((tsrr_pkg::DIV_NUM_W + 1)'(q1_q)
				                                  + {1'b0, div_rsp.quo});
				last_spark_q <= time_q;
			end
			if (state_q == tsrr_pkg::B_EVAL) begin
				idx_q <= '0;
			end else if (out_load) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (pop) begin
			time_q <= head[TIME_BITS-1:0];
			diff_q <= head[TIME_BITS-1:0] - last_spark_q;
			kind_q <= tsrr_pkg::op_t'(head[TIME_BITS]);
		end
		if (state_q == tsrr_pkg::B_EVAL) begin
			dir_q <= spark_direct;
			rpm_q <= {1'b0, smoothed_q};
		end
		if (state_q == tsrr_pkg::B_DIV_A && div_rsp.done) begin
			q1_q <= div_rsp.quo[15:0];
		end
		if (state_q == tsrr_pkg::B_DIV_R && div_rsp.done) begin
			rpm_q <= div_rsp.quo[tsrr_pkg::RPTR_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= tsrr_pkg::pkt_byte(idx_q, rpm_q);
			out_last_q <= idx_end;
			out_rpm_q  <= rpm_q;
		end
	end

endmodule
